// ===== design/qdf_pkg.sv =====
`timescale 1ns / 1ps

package qdf_pkg;

	// Command codes carried in the cmd field
	typedef enum logic [1:0] {
		CMD_SAMPLE   = 2'd0,
		CMD_RAW      = 2'd1,
		CMD_FILTERED = 2'd2,
		CMD_TICK     = 2'd3
	} cmd_t;

	// One request as it sits in the input stage
	typedef struct packed {
		cmd_t cmd;
		logic pin_a;
		logic pin_b;
	} item_t;

	// Result handed from the core to the output register
	typedef struct packed {
		logic             valid;
		logic signed [7:0] value;
	} res_t;

	localparam logic [15:0] HOLDOFF_RESET = 16'd100;

	localparam logic signed [7:0] STEP_POS  = 8'sd1;
	localparam logic signed [7:0] STEP_NEG  = -8'sd1;
	localparam logic signed [7:0] STEP_NONE = 8'sd0;

	// x4 decode: step for current phase cur after previous phase prev
	function automatic logic signed [7:0] step_of(input logic [1:0] cur, input logic [1:0] prev);
		logic signed [7:0] s;
		s = STEP_NONE;
		case ({cur, prev})
			4'b0001, 4'b1000, 4'b0111, 4'b1110: s = STEP_POS;
			4'b0010, 4'b0100, 4'b1011, 4'b1101: s = STEP_NEG;
			default: s = STEP_NONE;
		endcase
		return s;
	endfunction

endpackage

// ===== design/quadrature_decoder_filtered_top.sv =====
`timescale 1ns / 1ps

// Quadrature decoder (x4) with a rate-limited filtered read.
// Input channel in_valid/in_ready carries one request: cmd with pin_a/pin_b.
//   cmd 0 samples the pins, 1 is a raw read, 2 a filtered read, 3 a 1 ms tick.
// Output channel out_valid/out_ready carries increment, one per read request;
//   samples and ticks produce nothing on the output.
// cfg_wr_en/cfg_wr_data write holdoff_ms in the same cycle; write it only
//   while no request is in flight.
// A request is captured in the input stage register and processed from there;
//   a read result is then captured in the result register that drives out_valid.
// Throughput: one request per clock while no read waits behind a full result
//   register; the state update sits between the input stage and result registers.
// Reset clears the phase, the accumulator and the millisecond count, sets
//   holdoff_ms to 100 and empties both registers.
// When the receiver stalls, the result register holds its value; samples and
//   ticks keep flowing, and in_ready drops only once a read waits in the input
//   stage behind a full result register.
module quadrature_decoder_filtered_top
	import qdf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        cmd,
	input  logic              pin_a,
	input  logic              pin_b,
	output logic              out_valid,
	input  logic              out_ready,
	output logic signed [7:0] increment,
	input  logic              cfg_wr_en,
	input  logic [15:0]       cfg_wr_data
);

	item_t item;
	item_t item_s1;
	logic  fire;
	logic  slot_free;
	res_t  res;

	assign item.cmd   = cmd_t'(cmd);
	assign item.pin_a = pin_a;
	assign item.pin_b = pin_b;

	qdf_in_reg u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.item      (item),
		.slot_free (slot_free),
		.fire      (fire),
		.item_s1   (item_s1)
	);

	qdf_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.fire        (fire),
		.item_s1     (item_s1),
		.res         (res)
	);

	qdf_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.slot_free (slot_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.increment (increment)
	);

endmodule

// ===== design/qdf_in_reg.sv =====
`timescale 1ns / 1ps

module qdf_in_reg
	import qdf_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t item,
	input  logic  slot_free,
	output logic  fire,
	output item_t item_s1
);

	logic valid_s1;
	logic needs_slot;

	// reads need room in the output register, samples and ticks do not
	assign needs_slot = (item_s1.cmd == CMD_RAW) || (item_s1.cmd == CMD_FILTERED);
	assign fire       = valid_s1 && (!needs_slot || slot_free);
	assign in_ready   = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= item;
		end
	end

`ifndef SYNTH
	// a held request only leaves the stage when it is processed
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !fire |=> valid_s1 && $stable(item_s1))
		else $error("input stage lost a request");
`endif

endmodule

// ===== design/qdf_core.sv =====
`timescale 1ns / 1ps

module qdf_core
	import qdf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        fire,
	input  item_t       item_s1,
	output res_t        res
);

	logic [15:0]       holdoff_q;
	logic [1:0]        phase_q;
	logic [7:0]        sum_q;
	logic [15:0]       since_q;

	logic [1:0]        cur_phase;
	logic signed [7:0] step;
	logic              half_nz;
	logic              elapsed;
	logic              pass;

	assign cur_phase = {item_s1.pin_a, item_s1.pin_b};
	assign step      = step_of(cur_phase, phase_q);
	// half truncated toward zero is zero for 0, +1 and -1
	assign half_nz   = (sum_q != 8'h00) && (sum_q != 8'h01) && (sum_q != 8'hFF);
	assign elapsed   = since_q >= holdoff_q;
	assign pass      = half_nz && elapsed;

	// holdoff register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holdoff_q <= HOLDOFF_RESET;
		end else if (cfg_wr_en) begin
			holdoff_q <= cfg_wr_data;
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
			sum_q   <= 8'd0;
			since_q <= 16'd0;
		end else if (fire) begin
			unique case (item_s1.cmd)
				CMD_SAMPLE: begin
					phase_q <= cur_phase;
					sum_q   <= sum_q + step;
				end
				CMD_RAW: begin
					sum_q <= 8'd0;
				end
				CMD_FILTERED: begin
					sum_q <= 8'd0;
					if (pass) begin
						since_q <= 16'd0;
					end
				end
				CMD_TICK: begin
					if (!elapsed) begin
						since_q <= since_q + 16'd1;
					end
				end
			endcase
		end
	end

	// result for reads
	always_comb begin
		res.valid = fire && ((item_s1.cmd == CMD_RAW) || (item_s1.cmd == CMD_FILTERED));
		if (item_s1.cmd == CMD_RAW) begin
			res.value = sum_q;
		end else if (pass) begin
			res.value = sum_q[7] ? STEP_NEG : STEP_POS;
		end else begin
			res.value = STEP_NONE;
		end
	end

`ifndef SYNTH
	// any read empties the accumulator
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		fire && ((item_s1.cmd == CMD_RAW) || (item_s1.cmd == CMD_FILTERED)) |=> sum_q == 8'd0)
		else $error("accumulator not cleared by read");

	// a nonzero filtered answer restarts the holdoff
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && (item_s1.cmd == CMD_FILTERED) && (res.value != STEP_NONE)
		|=> since_q == 16'd0)
		else $error("holdoff not restarted");

	// a filtered answer is only ever -1, 0 or +1
	a_filt: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && (item_s1.cmd == CMD_FILTERED)
		|-> (res.value == STEP_NONE) || (res.value == STEP_POS) || (res.value == STEP_NEG))
		else $error("filtered answer out of range");
`endif

endmodule

// ===== design/qdf_out_reg.sv =====
`timescale 1ns / 1ps

module qdf_out_reg
	import qdf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  res_t              res,
	output logic              slot_free,
	output logic              out_valid,
	input  logic              out_ready,
	output logic signed [7:0] increment
);

	logic              valid_q;
	logic signed [7:0] value_q;

	assign slot_free = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign increment = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res.valid) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			value_q <= res.value;
		end
	end

`ifndef SYNTH
	// never overwrite a result that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> slot_free)
		else $error("result register overwritten");
`endif

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import qdf_pkg::*;

	localparam int IDLE_LIMIT = 3000;
	localparam int SETTLE     = 6;

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              in_valid    = 1'b0;
	logic              in_ready;
	logic [1:0]        cmd         = CMD_SAMPLE;
	logic              pin_a       = 1'b0;
	logic              pin_b       = 1'b0;
	logic              out_valid;
	logic              out_ready   = 1'b0;
	logic signed [7:0] increment;
	logic              cfg_wr_en   = 1'b0;
	logic [15:0]       cfg_wr_data = 16'd0;

	// requests waiting to be driven, increments waiting to come back
	item_t             req_q[$];
	logic signed [7:0] incr_q[$];

	// decoder state as predicted
	logic [15:0]       holdoff_ms = HOLDOFF_RESET;
	logic [15:0]       elapsed_ms = 16'd0;
	logic [7:0]        count_acc  = 8'd0;
	logic [1:0]        prev_phase = 2'b00;

	// last phase queued, so rotations can be built ahead of the driver
	logic [1:0]        queued_phase = 2'b00;
	int                queued_reqs  = 0;

	int                errors      = 0;
	int                idle_cycles = 0;
	int                tx_gap      = 0;
	int                tx_calm     = 0;
	int                rx_stall    = 0;
	int                rx_calm     = 0;
	bit                req_taken   = 1'b0;
	item_t             seen_req;
	item_t             next_req;
	logic signed [7:0] want_incr;

	always #2 clk = ~clk;

	quadrature_decoder_filtered_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.pin_a       (pin_a),
		.pin_b       (pin_b),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.increment   (increment),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	// position of a phase on the forward rotation 00 -> 10 -> 11 -> 01
	function automatic int ring_pos(input logic [1:0] ph);
		case (ph)
			2'b00:   return 0;
			2'b10:   return 1;
			2'b11:   return 2;
			default: return 3;
		endcase
	endfunction

	function automatic logic [1:0] ring_phase(input int p);
		case (p & 3)
			0:       return 2'b00;
			1:       return 2'b10;
			2:       return 2'b11;
			default: return 2'b01;
		endcase
	endfunction

	// advance the predicted state by one request, queue any increment it yields
	function automatic void apply_request(input item_t it);
		int                d;
		int                half;
		logic signed [7:0] s;
		case (it.cmd)
			CMD_SAMPLE: begin
				d = (ring_pos({it.pin_a, it.pin_b}) - ring_pos(prev_phase)) & 3;
				if (d == 1)
					count_acc = count_acc + 8'd1;
				else if (d == 3)
					count_acc = count_acc - 8'd1;
				prev_phase = {it.pin_a, it.pin_b};
			end
			CMD_RAW: begin
				incr_q.push_back(count_acc);
				count_acc = 8'd0;
			end
			CMD_FILTERED: begin
				s = count_acc;
				count_acc = 8'd0;
				half = int'(s) / 2;
				if (half == 0 || elapsed_ms < holdoff_ms) begin
					incr_q.push_back(8'sd0);
				end else begin
					elapsed_ms = 16'd0;
					incr_q.push_back(half > 0 ? 8'sd1 : -8'sd1);
				end
			end
			CMD_TICK: begin
				if (elapsed_ms < holdoff_ms)
					elapsed_ms = elapsed_ms + 16'd1;
			end
		endcase
	endfunction

	task automatic flag_error(input string msg);
		$display("%0t ns: %s", $time, msg);
		errors++;
	endtask

	// wait length for one request or result; sometimes a stretch with no waits
	task automatic draw_wait(inout int calm, output int cycles);
		if (calm > 0) begin
			calm--;
			cycles = 0;
		end else if ($urandom_range(0, 7) == 0) begin
			calm = $urandom_range(8, 40);
			cycles = 0;
		end else begin
			cycles = $urandom_range(0, 11);
		end
	endtask

	task automatic push_req(input cmd_t c, input logic a, input logic b);
		item_t it;
		it.cmd   = c;
		it.pin_a = a;
		it.pin_b = b;
		req_q.push_back(it);
		if (c == CMD_SAMPLE)
			queued_phase = {a, b};
		queued_reqs++;
	endtask

	// request with random pins, which the block ignores for all but a sample
	task automatic push_cmd(input cmd_t c);
		push_req(c, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endtask

	// n samples stepping dir positions around the rotation each
	task automatic spin(input int dir, input int n);
		logic [1:0] ph;
		for (int i = 0; i < n; i++) begin
			ph = ring_phase(ring_pos(queued_phase) + dir);
			push_req(CMD_SAMPLE, ph[1], ph[0]);
		end
	endtask

	task automatic tick_burst(input int n);
		for (int i = 0; i < n; i++)
			push_cmd(CMD_TICK);
	endtask

	// mostly clean rotations followed by a read, with ticks and noise mixed in
	task automatic rand_phase(input int n, input int max_ticks);
		int stop;
		int sel;
		int len;
		stop = queued_reqs + n;
		while (queued_reqs < stop) begin
			sel = $urandom_range(0, 99);
			if (sel < 45) begin
				len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 140)
				                                   : $urandom_range(0, 12);
				spin($urandom_range(0, 1) ? 1 : -1, len);
				push_cmd($urandom_range(0, 9) < 6 ? CMD_FILTERED : CMD_RAW);
			end else if (sel < 62) begin
				tick_burst($urandom_range(1, max_ticks));
			end else if (sel < 75) begin
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++)
					push_req(CMD_SAMPLE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end else if (sel < 85) begin
				push_cmd($urandom_range(0, 1) ? CMD_FILTERED : CMD_RAW);
			end else begin
				push_cmd(cmd_t'($urandom_range(0, 3)));
			end
		end
	endtask

	// block until every request went in and every increment came out
	task automatic wait_drained();
		while (req_q.size() != 0 || in_valid || incr_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_holdoff(input logic [15:0] v);
		wait_drained();
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// request driver: one request per handshake, random gaps between them
	always @(negedge clk) begin
		if (!(in_valid && !req_taken)) begin
			if (tx_gap > 0) begin
				tx_gap--;
				in_valid <= 1'b0;
			end else if (req_q.size() != 0) begin
				next_req = req_q.pop_front();
				cmd      <= next_req.cmd;
				pin_a    <= next_req.pin_a;
				pin_b    <= next_req.pin_b;
				in_valid <= 1'b1;
				draw_wait(tx_calm, tx_gap);
			end else begin
				in_valid <= 1'b0;
			end
		end
		// result side back-pressure
		if (rx_stall > 0) begin
			rx_stall--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// monitor: predict on accepted requests, check accepted increments
	always @(posedge clk) begin
		req_taken = 1'b0;
		if (arst_n) begin
			if (cfg_wr_en)
				holdoff_ms = cfg_wr_data;
			if (in_valid && in_ready) begin
				req_taken      = 1'b1;
				seen_req.cmd   = cmd_t'(cmd);
				seen_req.pin_a = pin_a;
				seen_req.pin_b = pin_b;
				apply_request(seen_req);
			end
			if (out_valid && out_ready) begin
				draw_wait(rx_calm, rx_stall);
				if (incr_q.size() == 0) begin
					flag_error($sformatf("increment %0d with no read outstanding", increment));
				end else begin
					want_incr = incr_q.pop_front();
					if (increment !== want_incr)
						flag_error($sformatf("increment got %0d expected %0d",
							increment, want_incr));
				end
			end
			// watchdog
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("quadrature_decoder_filtered_top regression: fail");
				$finish;
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset holdoff: empty read, both directions, no-step transitions
		push_req(CMD_RAW, 1'b1, 1'b1);
		spin(1, 4);
		push_req(CMD_RAW, 1'b0, 1'b1);
		spin(-1, 3);
		push_req(CMD_RAW, 1'b1, 1'b0);
		spin(2, 1);
		spin(0, 1);
		push_req(CMD_RAW, 1'b0, 1'b0);
		// filtered read inside holdoff still clears the count
		spin(1, 5);
		push_req(CMD_FILTERED, 1'b1, 1'b1);
		push_req(CMD_RAW, 1'b0, 1'b0);
		// run the ms count into saturation, then pass once and get held off
		tick_burst(102);
		spin(1, 4);
		push_cmd(CMD_FILTERED);
		spin(1, 4);
		push_cmd(CMD_FILTERED);
		spin(1, 1);
		push_cmd(CMD_FILTERED);
		rand_phase(150, 40);

		// zero holdoff: most negative sum, accumulator wrap, every nonzero half passes
		set_holdoff(16'd0);
		push_cmd(CMD_RAW);
		spin(-1, 128);
		push_cmd(CMD_FILTERED);
		spin(-1, 1);
		push_cmd(CMD_FILTERED);
		spin(1, 130);
		push_cmd(CMD_RAW);
		spin(1, 3);
		push_cmd(CMD_FILTERED);
		spin(-1, 2);
		push_cmd(CMD_FILTERED);
		rand_phase(150, 3);

		set_holdoff(16'd40);
		rand_phase(150, 50);
		// lowered below a saturated count
		set_holdoff(16'd3);
		rand_phase(150, 6);
		set_holdoff(16'hFFFF);
		rand_phase(100, 40);
		set_holdoff(16'd1);
		rand_phase(150, 3);
		set_holdoff(16'd12);
		rand_phase(150, 16);

		wait_drained();
		if (errors == 0)
			$display("quadrature_decoder_filtered_top regression: pass");
		else
			$display("quadrature_decoder_filtered_top regression: fail");
		$finish;
	end

endmodule
